// ----- design/csctri_pkg.sv -----
// Package for the per-node triangle counter: command codes, sequencer states,
// field widths and parameter defaults. No dependencies.
package csctri_pkg;

   localparam int MAX_NODES_DEF = 1024;
   localparam int MAX_EDGES_DEF = 8192;

   localparam int CMD_W   = 2;
   localparam int INDEX_W = 13;
   localparam int VALUE_W = 14;
   localparam int NODE_W  = 10;
   localparam int TRI_W   = 19;
   localparam int CNT_W   = 11;
   localparam int ROW_W   = 10;

   typedef enum logic [CMD_W-1:0] {
      CMD_COL_START = 2'd0,
      CMD_ROW_INDEX = 2'd1,
      CMD_COUNT     = 2'd2
   } command_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_NLO,
      S_NHI,
      S_NEND,
      S_JCHK,
      S_JRD,
      S_ALO,
      S_AHI,
      S_KCHK,
      S_KRD,
      S_SRCH,
      S_SCMP,
      S_DONE
   } state_type;

endpackage

// ----- design/csc_node_triangle_counter_unit.sv -----
// Top level of the per-node triangle counter: graph stores, search sequencer
// and response register. Depends on csctri_pkg.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_command, req_index, req_value
//  rsp      out        rsp_valid/rsp_stall   rsp_node, rsp_triangles, rsp_error
//  csr      in         csr_wr_en             csr_wr_data (node_count)
//
// Store writes are taken while the sequencer idles; a count on a bad node goes
// straight to S_DONE. A good count walks each pair j < k of the node's column and
// binary-searches the column of row j for row k; each step waits on a read.
// Reset is synchronous; the stores are not cleared. A pending response held by
// rsp_stall does not block store writes; a finished count waits for it.
module csc_node_triangle_counter_unit #(
   parameter int MAX_NODES = csctri_pkg::MAX_NODES_DEF,
   parameter int MAX_EDGES = csctri_pkg::MAX_EDGES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [csctri_pkg::CMD_W-1:0]     req_command,
   input  logic [csctri_pkg::INDEX_W-1:0]   req_index,
   input  logic [csctri_pkg::VALUE_W-1:0]   req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [csctri_pkg::NODE_W-1:0]    rsp_node,
   output logic [csctri_pkg::TRI_W-1:0]     rsp_triangles,
   output logic                             rsp_error,
   input  logic                             csr_wr_en,
   input  logic [csctri_pkg::CNT_W-1:0]     csr_wr_data
);

   localparam int NAW = $clog2(MAX_NODES + 1);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int PW  = $clog2(MAX_EDGES + 1);

   logic [csctri_pkg::VALUE_W-1:0] col_mem [MAX_NODES+1];
   logic [csctri_pkg::ROW_W-1:0]   row_mem [MAX_EDGES];

   csctri_pkg::state_type state_ff, state_in;

   logic [csctri_pkg::CNT_W-1:0]   node_count_ff;
   logic [csctri_pkg::VALUE_W-1:0] col_rd_ff;
   logic [csctri_pkg::ROW_W-1:0]   row_rd_ff;
   logic [NAW-1:0]                 col_raddr;
   logic [PW-1:0]                  row_raddr;

   logic [csctri_pkg::NODE_W-1:0]  node_ff, node_in;
   logic                           err_ff, err_in;
   logic [NAW-1:0]                 n_ff, n_in;
   logic [PW-1:0]                  lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in, k_ff, k_in;
   logic [csctri_pkg::ROW_W-1:0]   a_ff, a_in, want_ff, want_in;
   logic [PW-1:0]                  alo_ff, alo_in, ahi_ff, ahi_in;
   logic [PW-1:0]                  left_ff, left_in, rgt_ff, rgt_in, mid_ff, mid_in;
   logic [csctri_pkg::TRI_W-1:0]   cnt_ff, cnt_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [csctri_pkg::NODE_W-1:0]  rsp_node_ff, rsp_node_in;
   logic [csctri_pkg::TRI_W-1:0]   rsp_tri_ff, rsp_tri_in;
   logic                           rsp_err_ff, rsp_err_in;

   logic                           req_take;
   logic                           a_empty;
   logic [PW-1:0]                  col_clamp;
   logic [PW:0]                    mid_sum;

   function automatic logic [PW-1:0] clamp_ptr(input logic [csctri_pkg::VALUE_W-1:0] v);
      logic [PW-1:0] r;
      if (32'(v) > 32'(MAX_EDGES)) begin
         r = PW'(MAX_EDGES);
      end else begin
         r = PW'(v);
      end
      return r;
   endfunction

   assign req_stall     = (state_ff != csctri_pkg::S_IDLE);
   assign req_take      = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_node      = rsp_node_ff;
   assign rsp_triangles = rsp_tri_ff;
   assign rsp_error     = rsp_err_ff;

   assign a_empty   = (32'(a_ff) >= 32'(MAX_NODES));
   assign col_clamp = clamp_ptr(col_rd_ff);
   assign mid_sum   = (PW+1)'(left_ff) + (PW+1)'(rgt_ff) - (PW+1)'(1);

   always_ff @(posedge clock) begin
      if (req_take && req_command == csctri_pkg::CMD_COL_START
          && 32'(req_index) <= 32'(MAX_NODES)) begin
         col_mem[NAW'(req_index)] <= req_value;
      end
      col_rd_ff <= col_mem[col_raddr];
   end

   always_ff @(posedge clock) begin
      if (req_take && req_command == csctri_pkg::CMD_ROW_INDEX
          && 32'(req_index) < 32'(MAX_EDGES)) begin
         row_mem[EAW'(req_index)] <= req_value[csctri_pkg::ROW_W-1:0];
      end
      row_rd_ff <= row_mem[EAW'(row_raddr)];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= csctri_pkg::S_IDLE;
         rsp_valid_ff  <= 1'b0;
         node_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      err_ff      <= err_in;
      n_ff        <= n_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      a_ff        <= a_in;
      want_ff     <= want_in;
      alo_ff      <= alo_in;
      ahi_ff      <= ahi_in;
      left_ff     <= left_in;
      rgt_ff      <= rgt_in;
      mid_ff      <= mid_in;
      cnt_ff      <= cnt_in;
      rsp_node_ff <= rsp_node_in;
      rsp_tri_ff  <= rsp_tri_in;
      rsp_err_ff  <= rsp_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      err_in       = err_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      want_in      = want_ff;
      alo_in       = alo_ff;
      ahi_in       = ahi_ff;
      left_in      = left_ff;
      rgt_in       = rgt_ff;
      mid_in       = mid_ff;
      cnt_in       = cnt_ff;
      col_raddr    = '0;
      row_raddr    = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_node_in  = rsp_node_ff;
      rsp_tri_in   = rsp_tri_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         csctri_pkg::S_IDLE: begin
            if (req_take && req_command == csctri_pkg::CMD_COUNT) begin
               node_in = req_index[csctri_pkg::NODE_W-1:0];
               cnt_in  = '0;
               n_in    = NAW'(req_index);
               if (32'(req_index) >= 32'(node_count_ff)
                   || 32'(req_index) >= 32'(MAX_NODES)) begin
                  err_in   = 1'b1;
                  state_in = csctri_pkg::S_DONE;
               end else begin
                  err_in   = 1'b0;
                  state_in = csctri_pkg::S_NLO;
               end
            end
         end
         csctri_pkg::S_NLO: begin
            col_raddr = n_ff;
            state_in  = csctri_pkg::S_NHI;
         end
         csctri_pkg::S_NHI: begin
            lo_in     = col_clamp;
            col_raddr = n_ff + NAW'(1);
            state_in  = csctri_pkg::S_NEND;
         end
         csctri_pkg::S_NEND: begin
            hi_in    = (col_clamp < lo_ff) ? lo_ff : col_clamp;
            j_in     = lo_ff;
            state_in = csctri_pkg::S_JCHK;
         end
         csctri_pkg::S_JCHK: begin
            row_raddr = j_ff;
            if ((PW+1)'(j_ff) + (PW+1)'(1) < (PW+1)'(hi_ff)) begin
               state_in = csctri_pkg::S_JRD;
            end else begin
               state_in = csctri_pkg::S_DONE;
            end
         end
         csctri_pkg::S_JRD: begin
            a_in      = row_rd_ff;
            col_raddr = NAW'(row_rd_ff);
            k_in      = j_ff + PW'(1);
            state_in  = csctri_pkg::S_ALO;
         end
         csctri_pkg::S_ALO: begin
            alo_in    = a_empty ? '0 : col_clamp;
            col_raddr = NAW'(a_ff) + NAW'(1);
            state_in  = csctri_pkg::S_AHI;
         end
         csctri_pkg::S_AHI: begin
            if (a_empty) begin
               ahi_in = '0;
            end else begin
               ahi_in = (col_clamp < alo_ff) ? alo_ff : col_clamp;
            end
            state_in = csctri_pkg::S_KCHK;
         end
         csctri_pkg::S_KCHK: begin
            row_raddr = k_ff;
            if (k_ff < hi_ff) begin
               state_in = csctri_pkg::S_KRD;
            end else begin
               j_in     = j_ff + PW'(1);
               state_in = csctri_pkg::S_JCHK;
            end
         end
         csctri_pkg::S_KRD: begin
            want_in  = row_rd_ff;
            left_in  = alo_ff;
            rgt_in   = ahi_ff;
            state_in = csctri_pkg::S_SRCH;
         end
         csctri_pkg::S_SRCH: begin
            mid_in    = PW'(mid_sum >> 1);
            row_raddr = PW'(mid_sum >> 1);
            if (left_ff < rgt_ff) begin
               state_in = csctri_pkg::S_SCMP;
            end else begin
               k_in     = k_ff + PW'(1);
               state_in = csctri_pkg::S_KCHK;
            end
         end
         csctri_pkg::S_SCMP: begin
            if (row_rd_ff < want_ff) begin
               left_in  = mid_ff + PW'(1);
               state_in = csctri_pkg::S_SRCH;
            end else if (row_rd_ff == want_ff) begin
               if (cnt_ff != '1) begin
                  cnt_in = cnt_ff + csctri_pkg::TRI_W'(1);
               end
               k_in     = k_ff + PW'(1);
               state_in = csctri_pkg::S_KCHK;
            end else begin
               rgt_in   = mid_ff;
               state_in = csctri_pkg::S_SRCH;
            end
         end
         csctri_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_node_in  = node_ff;
               rsp_tri_in   = err_ff ? '0 : cnt_ff;
               rsp_err_in   = err_ff;
               state_in     = csctri_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = csctri_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- design/csctri_checker.sv -----
// Port-level checks for the triangle counter, bound to the top level.
// Depends on csctri_pkg and csc_node_triangle_counter_unit.
module csctri_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [csctri_pkg::CMD_W-1:0]   req_command,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [csctri_pkg::NODE_W-1:0]  rsp_node,
   input logic [csctri_pkg::TRI_W-1:0]   rsp_triangles,
   input logic                           rsp_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_triangles) && $stable(rsp_node))
      else $error("stalled response transaction changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_triangles == '0)
      else $error("error response carries a nonzero count");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == csctri_pkg::CMD_COUNT |=> req_stall)
      else $error("count transaction did not stall the request channel");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command != csctri_pkg::CMD_COUNT && !rsp_valid
      |=> !rsp_valid)
      else $error("store write produced a response");

endmodule

bind csc_node_triangle_counter_unit csctri_checker u_csctri_checker (.*);

// ----- sim/csctri_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the per-node triangle counter testbench: mirrors the graph
// stores and node_count, predicts each count transaction and checks results.
// Depends on csctri_pkg.
package csctri_tb_pkg;
   import csctri_pkg::*;

   localparam int unsigned NODE_SLOTS    = MAX_NODES_DEF;
   localparam int unsigned EDGE_SLOTS    = MAX_EDGES_DEF;
   localparam int unsigned TRIANGLE_CEIL = (1 << TRI_W) - 1;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [TRI_W-1:0]  triangles;
      logic              error;
   } count_result_type;

   class node_triangle_board;
      logic [VALUE_W-1:0] col_start [0:NODE_SLOTS];
      bit                 col_known [0:NODE_SLOTS];
      logic [ROW_W-1:0]   row_entry [0:EDGE_SLOTS-1];
      bit                 row_known [0:EDGE_SLOTS-1];
      int unsigned        node_limit;
      bit                 blank_read;
      count_result_type   awaited [$];
      int unsigned        faults;

      function new();
         node_limit = 0;
         faults     = 0;
         blank_read = 0;
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function void set_node_limit(int unsigned v);
         node_limit = v;
      endfunction

      function int unsigned read_col(int unsigned c);
         int unsigned v;
         if (!col_known[c]) blank_read = 1;
         v = col_start[c];
         return (v > EDGE_SLOTS) ? EDGE_SLOTS : v;
      endfunction

      function logic [ROW_W-1:0] read_row(int unsigned a);
         if (!row_known[a]) blank_read = 1;
         return row_entry[a];
      endfunction

      function void span_of(int unsigned c, output int unsigned lo, output int unsigned hi);
         lo = 0;
         hi = 0;
         if (c < NODE_SLOTS) begin
            lo = read_col(c);
            hi = read_col(c + 1);
            if (hi < lo) hi = lo;
         end
      endfunction

      function bit row_in_column(int unsigned c, logic [ROW_W-1:0] want);
         int unsigned      lo, hi;
         int               left, right, mid;
         logic [ROW_W-1:0] probe;
         span_of(c, lo, hi);
         left  = lo;
         right = int'(hi) - 1;
         while (left <= right) begin
            mid   = (left + right) / 2;
            probe = read_row(mid);
            if (probe < want) left = mid + 1;
            else if (probe == want) return 1;
            else right = mid - 1;
         end
         return 0;
      endfunction

      function int unsigned pair_hits(int unsigned n);
         int unsigned      lo, hi, cnt;
         logic [ROW_W-1:0] a;
         cnt = 0;
         span_of(n, lo, hi);
         for (int unsigned j = lo; j + 1 < hi; j++) begin
            a = read_row(j);
            for (int unsigned k = j + 1; k < hi; k++)
               if (row_in_column(a, read_row(k)) && cnt < TRIANGLE_CEIL) cnt++;
         end
         return cnt;
      endfunction

      // true when a count on idx touches only written entries and stays short
      function bit count_is_safe(int unsigned idx, int unsigned max_deg);
         int unsigned lo, hi;
         if (idx >= node_limit || idx >= NODE_SLOTS) return 1;
         blank_read = 0;
         span_of(idx, lo, hi);
         if (blank_read || hi - lo > max_deg) return 0;
         void'(pair_hits(idx));
         return !blank_read;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
                                 logic [VALUE_W-1:0] val);
         count_result_type res;
         case (cmd)
            CMD_COL_START: if (idx <= NODE_SLOTS) begin
               col_start[idx] = val;
               col_known[idx] = 1;
            end
            CMD_ROW_INDEX: if (idx < EDGE_SLOTS) begin
               row_entry[idx] = val[ROW_W-1:0];
               row_known[idx] = 1;
            end
            CMD_COUNT: begin
               res.node = idx[NODE_W-1:0];
               if (idx >= node_limit || idx >= NODE_SLOTS) begin
                  res.triangles = '0;
                  res.error     = 1'b1;
               end else begin
                  res.triangles = TRI_W'(pair_hits(idx));
                  res.error     = 1'b0;
               end
               awaited.push_back(res);
            end
            default: ;
         endcase
      endfunction

      function void check_count(logic [NODE_W-1:0] got_node, logic [TRI_W-1:0] got_triangles,
                                logic got_error);
         count_result_type want;
         if (awaited.size() == 0) begin
            faults++;
            $display("%0t: unexpected result node %0d triangles %0d error %0d",
                     $time, got_node, got_triangles, got_error);
            return;
         end
         want = awaited.pop_front();
         if (got_node !== want.node) begin
            faults++;
            $display("%0t: node expected %0d actual %0d", $time, want.node, got_node);
         end
         if (got_triangles !== want.triangles) begin
            faults++;
            $display("%0t: triangles at node %0d expected %0d actual %0d",
                     $time, want.node, want.triangles, got_triangles);
         end
         if (got_error !== want.error) begin
            faults++;
            $display("%0t: error at node %0d expected %0d actual %0d",
                     $time, want.node, want.error, got_error);
         end
      endfunction
   endclass

endpackage

// ----- sim/tb_csc_node_triangle_counter_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for csc_node_triangle_counter_unit: loads small graphs, issues
// count transactions under varied idling and checks every result against
// node_triangle_board. Depends on csctri_pkg and csctri_tb_pkg.
module tb_csc_node_triangle_counter_unit;
   import csctri_pkg::*;
   import csctri_tb_pkg::*;

   localparam int unsigned INDEX_MAX        = (1 << INDEX_W) - 1;
   localparam int unsigned VALUE_MAX        = MAX_EDGES_DEF;
   localparam int unsigned GRAPH_MAX        = 20;
   localparam int unsigned DEG_CAP          = 24;
   localparam int unsigned PHASES           = 8;
   localparam int unsigned RANDOM_PER_PHASE = 80;
   localparam int unsigned HOLD_CYCLES      = 6000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [CMD_W-1:0]   req_command;
   logic [INDEX_W-1:0] req_index;
   logic [VALUE_W-1:0] req_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [NODE_W-1:0]  rsp_node;
   logic [TRI_W-1:0]   rsp_triangles;
   logic               rsp_error;
   logic               csr_wr_en;
   logic [CNT_W-1:0]   csr_wr_data;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   bit          holding        = 1'b0;
   event        hold_go;
   int unsigned g_nodes, g_base, g_end;

   node_triangle_board board = new();

   csc_node_triangle_counter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_node      (rsp_node),
      .rsp_triangles (rsp_triangles),
      .rsp_error     (rsp_error),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         rsp_stall <= holding || ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      forever begin
         @hold_go;
         holding = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_count(rsp_node, rsp_triangles, rsp_error);
   end

   initial begin
      #1_000_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send(input logic [CMD_W-1:0] cmd, input int unsigned idx,
                       input int unsigned val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_index   <= idx[INDEX_W-1:0];
      req_value   <= val[VALUE_W-1:0];
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, idx[INDEX_W-1:0], val[VALUE_W-1:0]);
   endtask

   task automatic send_count(input int unsigned idx);
      if (!board.count_is_safe(idx, DEG_CAP)) idx = $urandom_range(INDEX_MAX, board.node_limit);
      send(CMD_COUNT, idx, $urandom_range(VALUE_MAX));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_node_count(input int unsigned v);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v[CNT_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_node_limit(v);
   endtask

   function automatic int unsigned wide_row(input int unsigned r);
      if (r == 0 && $urandom_range(7) == 0) return VALUE_MAX;
      return r + ($urandom_range(7) << ROW_W);
   endfunction

   // symmetric random graph on nodes 0..n-1; scramble reverses some columns
   task automatic load_graph(input int unsigned n, input int unsigned pct, input bit scramble);
      bit          adj [0:GRAPH_MAX-1][0:GRAPH_MAX-1];
      int unsigned edges, ptr, addr, r;
      bit          reverse;
      edges = 0;
      foreach (adj[i, j]) adj[i][j] = 1'b0;
      for (int unsigned i = 0; i < n; i++)
         for (int unsigned j = i + 1; j < n; j++)
            if ($urandom_range(99) < pct) begin
               adj[i][j] = 1'b1;
               adj[j][i] = 1'b1;
               edges += 2;
            end
      if (edges == 0 || $urandom_range(3) == 0) g_base = VALUE_MAX - edges;
      else g_base = $urandom_range(VALUE_MAX - edges);
      g_end   = g_base + edges;
      g_nodes = n;
      ptr = g_base;
      for (int unsigned c = 0; c < n; c++) begin
         send(CMD_COL_START, c, ptr);
         for (int unsigned k = 0; k < n; k++) ptr += adj[c][k];
      end
      send(CMD_COL_START, n, ptr);
      addr = g_base;
      for (int unsigned c = 0; c < n; c++) begin
         reverse = scramble && ($urandom_range(1) == 1);
         for (int unsigned i = 0; i < n; i++) begin
            r = reverse ? n - 1 - i : i;
            if (adj[c][r]) begin
               send(CMD_ROW_INDEX, addr, wide_row(r));
               addr++;
            end
         end
      end
   endtask

   task automatic random_item();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) send_count($urandom_range(g_nodes - 1));
      else if (pick < 70) send_count($urandom_range(g_nodes + 8, g_nodes));
      else if (pick < 78) send_count($urandom_range(INDEX_MAX));
      else if (pick < 83) send(CMD_UNUSED, $urandom_range(INDEX_MAX), $urandom_range(VALUE_MAX));
      else if (pick < 87) send(CMD_COL_START, $urandom_range(g_nodes), $urandom_range(g_end, g_base));
      else if (pick < 90) send(CMD_COL_START, $urandom_range(INDEX_MAX), $urandom_range(VALUE_MAX));
      else if (pick < 97 && g_end > g_base)
         send(CMD_ROW_INDEX, $urandom_range(g_end - 1, g_base), wide_row($urandom_range(g_nodes - 1)));
      else send(CMD_ROW_INDEX, $urandom_range(INDEX_MAX), $urandom_range(VALUE_MAX));
   endtask

   initial begin
      int unsigned tri_start [0:3];
      int unsigned tri_rows  [0:5];
      int unsigned n, limit;
      tri_start = '{8186, 8188, 8190, 8192};
      tri_rows  = '{1, 2, 0, 2, 0, 1};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_COL_START;
      req_index   = '0;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // single triangle at the top of the row store
      write_node_count(0);
      send_count(0);
      foreach (tri_start[c]) send(CMD_COL_START, c, tri_start[c]);
      foreach (tri_rows[a]) send(CMD_ROW_INDEX, 8186 + a, wide_row(tri_rows[a]));
      write_node_count(3);
      send_count(0);
      send_count(3);
      send_count(INDEX_MAX);
      send(CMD_UNUSED, INDEX_MAX, VALUE_MAX);
      send(CMD_COL_START, NODE_SLOTS - 1, 8186);
      send(CMD_COL_START, NODE_SLOTS, 8188);
      write_node_count(NODE_SLOTS);
      send_count(NODE_SLOTS - 1);
      send_count(NODE_SLOTS);
      // empty the last column, leaving column 1 long and out of order
      send(CMD_COL_START, 2, VALUE_MAX);
      send_count(1);
      send_count(2);
      // start past end: empty column
      send(CMD_COL_START, 0, 8190);
      send_count(0);

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 87;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 87;
            end
            default: begin
               send_idle_pct  = 36;
               recv_stall_pct = 36;
            end
         endcase
         n = $urandom_range(GRAPH_MAX, 3);
         case ($urandom_range(3))
            0: limit = NODE_SLOTS;
            1: limit = $urandom_range(n, 1);
            default: limit = n;
         endcase
         write_node_count(limit);
         load_graph(n, $urandom_range(70, 10), $urandom_range(2) == 0);
         if (phase % 4 == 0) begin
            -> hold_go;
            repeat (10) send_count($urandom_range(n - 1));
         end
         for (int unsigned i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i == RANDOM_PER_PHASE / 2) wait_drained();
            random_item();
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (board.faults == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
